// File: sv/assert_macros.svh
// shared assertion macros, clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define FAFC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// condition must never be seen at a clock edge out of reset
`define FAFC_NEVER(label, cond, msg) \
	`FAFC_ASSERT(label, !(cond), msg)

`endif

// File: sv/fafc_pkg.sv
package fafc_pkg;

	// cache geometry
	localparam int LINES       = 64;
	localparam int OFFSET_BITS = 10;
	localparam int ADDR_BITS   = 32;
	localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS;
	localparam int LINE_BITS   = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int CNT_BITS    = $clog2(LINES + 1);
	localparam int CFG_BITS    = 7;
	localparam int TOTAL_BITS  = 32;
	localparam int CFG_RESET   = 64;

	// search token handed from cell to cell
	typedef struct packed {
		logic                 active;
		logic                 found;
		logic [LINE_BITS-1:0] where;
		logic [TAG_BITS-1:0]  key;
	} probe_t;

	// tag write broadcast to all cells
	typedef struct packed {
		logic                 en;
		logic [LINE_BITS-1:0] idx;
		logic [TAG_BITS-1:0]  tag;
	} wr_t;

endpackage

// File: sv/fafc_if.sv
// lookup request channel
interface fafc_in_if import fafc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] access_address;

	modport source (output valid, output access_address, input ready);
	modport sink (input valid, input access_address, output ready);
endinterface

// lookup result channel
interface fafc_out_if import fafc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic [LINE_BITS-1:0]  line_index;
	logic [TAG_BITS-1:0]   block_number;
	logic [TOTAL_BITS-1:0] hit_total;
	logic [TOTAL_BITS-1:0] miss_total;

	modport source (output valid, output hit, output line_index, output block_number,
		output hit_total, output miss_total, input ready);
	modport sink (input valid, input hit, input line_index, input block_number,
		input hit_total, input miss_total, output ready);
endinterface

// File: sv/fafc_cell.sv
module fafc_cell import fafc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [LINE_BITS-1:0] idx,
	input  probe_t               probe_in,
	input  wr_t                  wr,
	output probe_t               probe_out
);

	logic [TAG_BITS-1:0]  tag_q;
	logic                 valid_q;
	logic                 active_q;
	logic                 found_q;
	logic [LINE_BITS-1:0] where_q;
	logic [TAG_BITS-1:0]  key_q;
	logic                 match;
	logic                 wr_hit;

	// compare the passing key against this line
	assign match  = valid_q && (tag_q == probe_in.key);
	assign wr_hit = wr.en && (wr.idx == idx);

	// tag storage
	always_ff @(posedge clk) begin
		if (wr_hit) begin
			tag_q <= wr.tag;
		end
	end

	// line valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_hit) begin
			valid_q <= 1'b1;
		end
	end

	// token control bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else begin
			active_q <= probe_in.active;
		end
	end

	// token payload, first match wins
	always_ff @(posedge clk) begin
		found_q <= probe_in.found || match;
		where_q <= probe_in.found ? probe_in.where : idx;
		key_q   <= probe_in.key;
	end

	assign probe_out = '{active: active_q, found: found_q, where: where_q, key: key_q};

endmodule

// File: sv/fafc_top.sv
// Fully associative lookup with round-robin (FIFO) line replacement.
// lookup carries one byte address per item; result returns one item per lookup
// with hit flag, line index, block number and saturating hit and miss totals.
// cfg_we/cfg_wdata set the number of lines in use (0 acts as 1, above 64 as 64);
// write it only while no lookup is in flight.
// A lookup token walks the chain of 64 line cells, one cell per cycle. The
// accepting edge launches the token, it moves through the cells, the token
// leaving the last cell is captured, and the update step then updates the
// state and loads the output register.
// One item is processed at a time: a new lookup is not taken during a search.
// The result sits in an output register; a new lookup is taken while it waits.
// If the receiver stalls, a finished search holds in the update step until the
// output register frees up, and lookup stays not ready meanwhile.
// Reset clears all valid flags, the fill count, the victim pointer and both
// totals, and sets the lines in use to 64; no clearing pass is needed.
`include "assert_macros.svh"

module fully_assoc_fifo_cache_lookup import fafc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	fafc_in_if.sink             lookup,
	fafc_out_if.source          result
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_SEARCH  = 2'd1;
	localparam logic [1:0] ST_RESOLVE = 2'd2;

	logic [1:0]            state_q;
	logic [CFG_BITS-1:0]   lines_q;
	logic [CNT_BITS-1:0]   fill_q;
	logic [LINE_BITS-1:0]  victim_q;
	logic [TOTAL_BITS-1:0] hits_q;
	logic [TOTAL_BITS-1:0] misses_q;
	logic [TAG_BITS-1:0]   block_q;
	logic                  found_q;
	logic [LINE_BITS-1:0]  where_q;
	logic                  launch_active_q;
	probe_t                chain [0:LINES];
	wr_t                   wr_cmd;

	logic                  in_fire;
	logic                  commit;
	logic                  out_valid_q;
	logic                  out_hit_q;
	logic [LINE_BITS-1:0]  out_line_q;
	logic [TAG_BITS-1:0]   out_block_q;
	logic [TOTAL_BITS-1:0] out_hits_q;
	logic [TOTAL_BITS-1:0] out_misses_q;

	logic [CNT_BITS-1:0]   limit;
	logic [LINE_BITS-1:0]  res_where;
	logic                  do_fill;
	logic [LINE_BITS-1:0]  victim_nx;
	logic [TOTAL_BITS-1:0] hits_nx;
	logic [TOTAL_BITS-1:0] misses_nx;

	assign lookup.ready = (state_q == ST_IDLE);
	assign in_fire      = lookup.valid && lookup.ready;
	assign commit       = (state_q == ST_RESOLVE) && (!out_valid_q || result.ready);

	// lines in use register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= CFG_BITS'(CFG_RESET);
		end else if (cfg_we) begin
			lines_q <= cfg_wdata;
		end
	end

	// effective line limit, clamped to 1..LINES
	always_comb begin
		if (lines_q == '0) begin
			limit = CNT_BITS'(1);
		end else if (32'(lines_q) > 32'(LINES)) begin
			limit = CNT_BITS'(LINES);
		end else begin
			limit = CNT_BITS'(lines_q);
		end
	end

	// launch token into the first cell, key held in block_q during the search
	assign chain[0] = '{active: launch_active_q, found: 1'b0, where: '0, key: block_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_active_q <= 1'b0;
		end else begin
			launch_active_q <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			block_q <= lookup.access_address[ADDR_BITS-1:OFFSET_BITS];
		end
	end

	// chain of line cells
	for (genvar i = 0; i < LINES; i++) begin : g_cell
		fafc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (LINE_BITS'(i)),
			.probe_in  (chain[i]),
			.wr        (wr_cmd),
			.probe_out (chain[i+1])
		);
	end

	// capture the token leaving the last cell
	always_ff @(posedge clk) begin
		if ((state_q == ST_SEARCH) && chain[LINES].active) begin
			found_q <= chain[LINES].found;
			where_q <= chain[LINES].where;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (chain[LINES].active) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hit/miss resolution and replacement choice
	always_comb begin
		do_fill   = 1'b0;
		res_where = where_q;
		if (!found_q) begin
			if (fill_q < limit) begin
				do_fill   = 1'b1;
				res_where = LINE_BITS'(fill_q);
			end else if (32'(victim_q) >= 32'(LINES)) begin
				res_where = '0;
			end else begin
				res_where = victim_q;
			end
		end
		if ((32'(res_where) + 32'd1) >= 32'(fill_q)) begin
			victim_nx = '0;
		end else begin
			victim_nx = res_where + LINE_BITS'(1);
		end
		hits_nx   = hits_q;
		misses_nx = misses_q;
		if (found_q) begin
			if (hits_q != '1) begin
				hits_nx = hits_q + TOTAL_BITS'(1);
			end
		end else if (misses_q != '1) begin
			misses_nx = misses_q + TOTAL_BITS'(1);
		end
	end

	// tag write on a miss
	assign wr_cmd = '{en: commit && !found_q, idx: res_where, tag: block_q};

	// fill count, victim pointer and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			victim_q <= '0;
			hits_q   <= '0;
			misses_q <= '0;
		end else if (commit) begin
			hits_q   <= hits_nx;
			misses_q <= misses_nx;
			if (!found_q) begin
				if (do_fill) begin
					fill_q <= fill_q + CNT_BITS'(1);
				end else begin
					victim_q <= victim_nx;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_hit_q    <= found_q;
			out_line_q   <= res_where;
			out_block_q  <= block_q;
			out_hits_q   <= hits_nx;
			out_misses_q <= misses_nx;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.hit          = out_hit_q;
	assign result.line_index   = out_line_q;
	assign result.block_number = out_block_q;
	assign result.hit_total    = out_hits_q;
	assign result.miss_total   = out_misses_q;

	// checks
	`FAFC_ASSERT(a_fill_bound, (32'(fill_q) <= 32'(LINES)), "fill count above line count")
	`FAFC_ASSERT(a_victim_in_fill, (fill_q == '0) || (CNT_BITS'(victim_q) < fill_q), "victim outside fill")
	`FAFC_NEVER(a_token_idle, chain[LINES].active && (state_q != ST_SEARCH), "token outside search")
	`FAFC_ASSERT(a_load_commit, $rose(out_valid_q) |-> $past(state_q == ST_RESOLVE), "early load")

endmodule
